/* rtl/crc_selectable_width_words_assert.svh */
// ----------------------------------------------------------------------------
// CRC selectable width assertion macros
// Shared concurrent assertion wrappers clocked on clk.
// ----------------------------------------------------------------------------
`ifndef CRC_SELECTABLE_WIDTH_WORDS_ASSERT_SVH
`define CRC_SELECTABLE_WIDTH_WORDS_ASSERT_SVH

// Checked only outside reset.
`define CRCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CRCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/crcw_pkg.sv */
// ----------------------------------------------------------------------------
// CRC selectable width package
// Widths, generator table and width helpers shared by the CRC block.
// ----------------------------------------------------------------------------
package crcw_pkg;

  localparam int WORD_BITS  = 16;
  localparam int CRC_BITS   = 15;
  localparam int WIDTH_BITS = 4;

  localparam logic [WIDTH_BITS-1:0] MIN_WIDTH   = 4'd3;
  localparam logic [WIDTH_BITS-1:0] RESET_WIDTH = 4'd15;

  // Generators in implicit +1 form, indexed by width; the x^width term is the top bit.
  localparam logic [15:0] GEN_TABLE [16] = '{
    16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0009, 16'h0012, 16'h0033,
    16'h0065, 16'h00E7, 16'h0119, 16'h0327, 16'h05DB, 16'h0987, 16'h1ABF,
    16'h27CF, 16'h4F23
  };

  function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
    return (w < MIN_WIDTH) ? MIN_WIDTH : w;
  endfunction

  function automatic logic [CRC_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
    return ~({CRC_BITS{1'b1}} << w);
  endfunction

  // Full generator with the +1 term restored; masking to the width drops the top term.
  function automatic logic [CRC_BITS-1:0] gen_poly(input logic [WIDTH_BITS-1:0] w);
    logic [16:0] full;
    full = {GEN_TABLE[w], 1'b1};
    return full[CRC_BITS-1:0];
  endfunction

endpackage

/* rtl/crcw_update.sv */
// ----------------------------------------------------------------------------
// CRC word update
// Folds one message word, MSB first, into the remainder at the given width.
// ----------------------------------------------------------------------------
module crcw_update
  import crcw_pkg::*;
(
  input  logic [CRC_BITS-1:0]   remainder,
  input  logic [WORD_BITS-1:0]  word,
  input  logic [WIDTH_BITS-1:0] width,
  output logic [CRC_BITS-1:0]   remainder_next
);

  logic [WIDTH_BITS-1:0] w_eff;
  logic [WIDTH_BITS-1:0] top_idx;
  logic [CRC_BITS-1:0]   mask;
  logic [CRC_BITS-1:0]   gen;

  assign w_eff   = eff_width(width);
  assign top_idx = w_eff - 4'd1;
  assign mask    = width_mask(w_eff);
  assign gen     = gen_poly(w_eff) & mask;

  // Unrolled bitwise divide; flattens to an XOR network per width.
  always_comb begin
    logic [CRC_BITS-1:0] r;
    logic                top;
    r = remainder & mask;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      top = r[top_idx] ^ word[i];
      r   = (r << 1) & mask;
      if (top) begin
        r = r ^ gen;
      end
    end
    remainder_next = r;
  end

endmodule

/* rtl/crc_selectable_width_words.sv */
// ----------------------------------------------------------------------------
// CRC selectable width over 16-bit words
// MSB-first CRC of 3 to 15 bits, zero init, no reflection, no final XOR.
// ----------------------------------------------------------------------------
// Takes one 16-bit word per cycle into an input register, sustained while no
// last word waits there on a held result; from that register the word is
// folded into the running remainder through a single 16-step XOR network
// and, on a word marked last, loads crc_value into the output register and
// raises out_valid.
// The remainder feedback through that network sets the rate.
// Only a last word produces an item; a waiting result stalls only a later
// last word. crc_width is taken from cfg_we/cfg_wdata, reset value 15;
// values below 3 act as 3. The CRC sits in the low width bits, upper bits zero.
// ----------------------------------------------------------------------------
`include "crc_selectable_width_words_assert.svh"

module crc_selectable_width_words
  import crcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [WIDTH_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WORD_BITS-1:0]  data_word,
  input  logic                  last_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CRC_BITS-1:0]   crc_value
);

  logic [WIDTH_BITS-1:0] crc_width;
  logic                  s1_valid;
  logic [WORD_BITS-1:0]  s1_word;
  logic                  s1_last;
  logic [CRC_BITS-1:0]   remainder;
  logic [CRC_BITS-1:0]   remainder_next;
  logic                  out_free;
  logic                  adv;

  assign out_free = !out_valid || out_ready;
  // A non-last word never needs the output register.
  assign adv      = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || adv;

  crcw_update u_update (
    .remainder      (remainder),
    .word           (s1_word),
    .width          (crc_width),
    .remainder_next (remainder_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width <= RESET_WIDTH;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      remainder <= '0;
    end else begin
      if (cfg_we) begin
        crc_width <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv && s1_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        if (s1_last) begin
          remainder <= '0;
        end else begin
          remainder <= remainder_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= data_word;
      s1_last <= last_word;
    end
    if (adv && s1_last) begin
      crc_value <= remainder_next;
    end
  end

  `CRCW_ASSERT_ALWAYS(a_reset_clear, rst |=> !s1_valid && !out_valid && remainder == '0, "reset did not clear pipeline")
  `CRCW_ASSERT(a_last_clears, adv && s1_last |=> remainder == '0, "remainder not cleared after last item")
  `CRCW_ASSERT(a_last_emits, adv && s1_last |=> out_valid, "last item produced no result")
  `CRCW_ASSERT(a_s1_hold, s1_valid && !adv |=> s1_valid && $stable(s1_word) && $stable(s1_last), "stalled input stage lost its item")
  `CRCW_ASSERT(a_stall_only_last, s1_valid && !adv |-> s1_last && out_valid && !out_ready, "input stage stalled without cause")

endmodule
